[hdl/jed_pkg.sv]
// Package for the Japanese encoding detector: words, byte classes, constants.
`timescale 1ns / 1ps
package jed_pkg;

  localparam int JED_QDEPTH  = 2;
  localparam int JED_ADDR_W  = 3;
  localparam int JED_DATA_W  = 32;

  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] BYTE_ASCII_HI = 8'h7F;
  localparam logic [7:0] BYTE_KANA_LO  = 8'hA0;
  localparam logic [7:0] BYTE_KANA_HI  = 8'hDF;
  localparam logic [7:0] BYTE_LEAD_LO  = 8'h81;
  localparam logic [7:0] BYTE_TRAIL_LO = 8'h40;
  localparam logic [7:0] BYTE_DEL      = 8'h7F;
  localparam logic [7:0] BYTE_SS2      = 8'h8E;
  localparam logic [7:0] BYTE_SS3      = 8'h8F;
  localparam logic [7:0] BYTE_PAIR_LO  = 8'hA1;
  localparam logic [7:0] BYTE_TOP      = 8'hFE;

  localparam logic [2:0] SJ_NUL   = 3'd0;
  localparam logic [2:0] SJ_ASCII = 3'd1;
  localparam logic [2:0] SJ_KANA  = 3'd2;
  localparam logic [2:0] SJ_LEAD  = 3'd3;
  localparam logic [2:0] SJ_BADB  = 3'd4;

  localparam logic [2:0] EU_NUL   = 3'd0;
  localparam logic [2:0] EU_ASCII = 3'd1;
  localparam logic [2:0] EU_SS2   = 3'd2;
  localparam logic [2:0] EU_SS3   = 3'd3;
  localparam logic [2:0] EU_PAIR  = 3'd4;
  localparam logic [2:0] EU_BADB  = 3'd5;

  localparam logic [0:0] REG_LAST_BROKEN_OK = 1'b0;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       stream_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0] sjis_score;
    logic [2:0] euc_score;
  } out_word_t;

  typedef struct packed {
    logic [2:0] sjis_class;
    logic       sjis_trail_ok;
    logic [2:0] euc_class;
    logic       euc_kana_ok;
    logic       euc_pair_ok;
    logic       last;
  } cls_word_t;

endpackage

[hdl/jed_fifo.sv]
// Small synchronous queue of words with full and empty flags.
`timescale 1ns / 1ps
module jed_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/jed_front.sv]
// Front end: classify each incoming byte for both validators.
`timescale 1ns / 1ps
module jed_front
  import jed_pkg::*;
(
  input  in_word_t  din,
  output cls_word_t cls
);

  logic [7:0] b;

  assign b = din.text_byte;

  always_comb begin
    cls.last          = din.stream_end;
    cls.sjis_trail_ok = (b >= BYTE_TRAIL_LO) && (b <= BYTE_TOP) && (b != BYTE_DEL);
    cls.euc_kana_ok   = (b >= BYTE_KANA_LO) && (b <= BYTE_KANA_HI);
    cls.euc_pair_ok   = (b >= BYTE_PAIR_LO) && (b <= BYTE_TOP);

    if (b == BYTE_NUL) begin
      cls.sjis_class = SJ_NUL;
    end else if (b <= BYTE_ASCII_HI) begin
      cls.sjis_class = SJ_ASCII;
    end else if ((b >= BYTE_KANA_LO) && (b <= BYTE_KANA_HI)) begin
      cls.sjis_class = SJ_KANA;
    end else if ((b >= BYTE_LEAD_LO) && (b <= BYTE_TOP)) begin
      cls.sjis_class = SJ_LEAD;
    end else begin
      cls.sjis_class = SJ_BADB;
    end

    if (b == BYTE_NUL) begin
      cls.euc_class = EU_NUL;
    end else if (b <= BYTE_ASCII_HI) begin
      cls.euc_class = EU_ASCII;
    end else if (b == BYTE_SS2) begin
      cls.euc_class = EU_SS2;
    end else if (b == BYTE_SS3) begin
      cls.euc_class = EU_SS3;
    end else if ((b >= BYTE_PAIR_LO) && (b <= BYTE_TOP)) begin
      cls.euc_class = EU_PAIR;
    end else begin
      cls.euc_class = EU_BADB;
    end
  end

endmodule

[hdl/jed_back.sv]
// Back end: run both validators on classified bytes and score at stream end.
`timescale 1ns / 1ps
module jed_back
  import jed_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      last_broken_ok,
  input  cls_word_t cls,
  input  logic      cls_empty,
  output logic      cls_pop,
  output out_word_t res,
  output logic      res_push,
  input  logic      res_full
);

  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_KANA  = 2'd1;
  localparam logic [1:0] PH_PAIR1 = 2'd2;
  localparam logic [1:0] PH_PAIR2 = 2'd3;

  logic       sj_wait, sj_kana, sj_dbl, sj_bad;
  logic       sj_wait_next, sj_kana_next, sj_dbl_next, sj_bad_next;
  logic [1:0] eu_phase, eu_phase_next;
  logic       eu_kana, eu_dbl, eu_p8f, eu_bad;
  logic       eu_kana_next, eu_dbl_next, eu_p8f_next, eu_bad_next;
  logic       sj_fin_bad, eu_fin_bad;
  logic       step;

  assign step     = !cls_empty && !res_full;
  assign cls_pop  = step;
  assign res_push = step && cls.last;

  always_comb begin
    sj_wait_next = sj_wait;
    sj_kana_next = sj_kana;
    sj_dbl_next  = sj_dbl;
    sj_bad_next  = sj_bad;
    if (!sj_bad) begin
      if (sj_wait) begin
        sj_wait_next = 1'b0;
        if (cls.sjis_trail_ok) begin
          sj_dbl_next = 1'b1;
        end else begin
          sj_bad_next = 1'b1;
        end
      end else begin
        case (cls.sjis_class)
          SJ_ASCII: ;
          SJ_KANA:  sj_kana_next = 1'b1;
          SJ_LEAD:  sj_wait_next = 1'b1;
          default:  sj_bad_next  = 1'b1;
        endcase
      end
    end
  end

  always_comb begin
    eu_phase_next = eu_phase;
    eu_kana_next  = eu_kana;
    eu_dbl_next   = eu_dbl;
    eu_p8f_next   = eu_p8f;
    eu_bad_next   = eu_bad;
    if (!eu_bad) begin
      case (eu_phase)
        PH_KANA: begin
          eu_phase_next = PH_START;
          if (cls.euc_kana_ok) begin
            eu_kana_next = 1'b1;
          end else begin
            eu_bad_next = 1'b1;
          end
        end
        PH_PAIR1: begin
          if (cls.euc_pair_ok) begin
            eu_phase_next = PH_PAIR2;
          end else begin
            eu_phase_next = PH_START;
            eu_bad_next   = 1'b1;
          end
        end
        PH_PAIR2: begin
          eu_phase_next = PH_START;
          if (cls.euc_pair_ok) begin
            eu_dbl_next = 1'b1;
          end else begin
            eu_bad_next = 1'b1;
          end
        end
        default: begin
          case (cls.euc_class)
            EU_ASCII: ;
            EU_SS2:   eu_phase_next = PH_KANA;
            EU_SS3: begin
              eu_p8f_next   = 1'b1;
              eu_phase_next = PH_PAIR1;
            end
            EU_PAIR:  eu_phase_next = PH_PAIR2;
            default:  eu_bad_next   = 1'b1;
          endcase
        end
      endcase
    end
  end

  always_comb begin
    sj_fin_bad = sj_bad_next || (sj_wait_next && !last_broken_ok);
    eu_fin_bad = eu_bad_next || ((eu_phase_next != PH_START) && !last_broken_ok);

    if (sj_fin_bad) begin
      res.sjis_score = 3'd0;
    end else if (sj_dbl_next) begin
      res.sjis_score = 3'd4;
    end else if (sj_kana_next) begin
      res.sjis_score = 3'd3;
    end else begin
      res.sjis_score = 3'd0;
    end

    if (eu_fin_bad) begin
      res.euc_score = 3'd0;
    end else if (eu_dbl_next) begin
      res.euc_score = (eu_kana_next || eu_p8f_next) ? 3'd3 : 3'd4;
    end else if (eu_kana_next) begin
      res.euc_score = 3'd2;
    end else begin
      res.euc_score = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sj_wait  <= 1'b0;
      sj_kana  <= 1'b0;
      sj_dbl   <= 1'b0;
      sj_bad   <= 1'b0;
      eu_phase <= PH_START;
      eu_kana  <= 1'b0;
      eu_dbl   <= 1'b0;
      eu_p8f   <= 1'b0;
      eu_bad   <= 1'b0;
    end else if (step) begin
      if (cls.last) begin
        sj_wait  <= 1'b0;
        sj_kana  <= 1'b0;
        sj_dbl   <= 1'b0;
        sj_bad   <= 1'b0;
        eu_phase <= PH_START;
        eu_kana  <= 1'b0;
        eu_dbl   <= 1'b0;
        eu_p8f   <= 1'b0;
        eu_bad   <= 1'b0;
      end else begin
        sj_wait  <= sj_wait_next;
        sj_kana  <= sj_kana_next;
        sj_dbl   <= sj_dbl_next;
        sj_bad   <= sj_bad_next;
        eu_phase <= eu_phase_next;
        eu_kana  <= eu_kana_next;
        eu_dbl   <= eu_dbl_next;
        eu_p8f   <= eu_p8f_next;
        eu_bad   <= eu_bad_next;
      end
    end
  end

endmodule

[hdl/japanese_encoding_detect_top.sv]
// Top level: Shift-JIS / EUC-JP detector with byte queue, validators and result queue.
// The back end pushes each result word into the result queue, whose head shows on dout.
// Throughput: one byte per cycle in the back end, while the result queue is not full.
// Reset: clears both queues, validator state and last_broken_ok.
// No clearing pass: the block takes bytes as soon as reset is released.
`timescale 1ns / 1ps
module japanese_encoding_detect_top
  import jed_pkg::*;
#(
  parameter int QDEPTH = JED_QDEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  in_word_t              din,
  output logic                  full,
  output logic                  empty,
  input  logic                  pop,
  output out_word_t             dout,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [JED_ADDR_W-1:0] paddr,
  input  logic [JED_DATA_W-1:0] pwdata,
  output logic [JED_DATA_W-1:0] prdata,
  output logic                  pready
);

  logic      last_broken_ok;
  cls_word_t cls_in, cls_out;
  logic      cls_full, cls_empty, cls_pop;
  out_word_t res;
  logic      res_push, res_full;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LAST_BROKEN_OK) ?
                  {{(JED_DATA_W-1){1'b0}}, last_broken_ok} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_broken_ok <= 1'b0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_LAST_BROKEN_OK)) begin
      last_broken_ok <= pwdata[0];
    end
  end

  jed_front u_front (
    .din (din),
    .cls (cls_in)
  );

  jed_fifo #(
    .WIDTH ($bits(cls_word_t)),
    .DEPTH (QDEPTH)
  ) u_cls_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cls_in),
    .full  (cls_full),
    .pop   (cls_pop),
    .dout  (cls_out),
    .empty (cls_empty)
  );

  assign full = cls_full;

  jed_back u_back (
    .clk            (clk),
    .rst            (rst),
    .last_broken_ok (last_broken_ok),
    .cls            (cls_out),
    .cls_empty      (cls_empty),
    .cls_pop        (cls_pop),
    .res            (res),
    .res_push       (res_push),
    .res_full       (res_full)
  );

  jed_fifo #(
    .WIDTH ($bits(out_word_t)),
    .DEPTH (QDEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (pop),
    .dout  (dout),
    .empty (empty)
  );

endmodule

[dv/jed_score_checker.sv]
// Score checker: predicts both scores per stream, compares words and checks register reads.
`timescale 1ns / 1ps
module jed_score_checker
  import jed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic                  full,
  input  in_word_t              din,
  input  logic                  empty,
  input  logic                  pop,
  input  out_word_t             dout,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [JED_ADDR_W-1:0] paddr,
  input  logic [JED_DATA_W-1:0] pwdata,
  input  logic [JED_DATA_W-1:0] prdata,
  input  logic                  pready,
  output int                    mismatch_count,
  output int                    pending
);

  typedef enum logic [1:0] {
    EUC_START,
    EUC_KANA_NEXT,
    EUC_PAIR_FIRST,
    EUC_PAIR_SECOND
  } euc_phase_t;

  logic       last_ok;
  logic       sj_wait;
  logic       sj_kana;
  logic       sj_dbl;
  logic       sj_bad;
  euc_phase_t eu_phase;
  logic       eu_kana;
  logic       eu_dbl;
  logic       eu_p8f;
  logic       eu_bad;
  out_word_t  score_q[$];

  initial begin
    mismatch_count = 0;
    pending = 0;
  end

  task automatic flag(input string msg);
    if (mismatch_count < 10) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatch_count++;
  endtask

  task automatic clear_validators();
    sj_wait  = 1'b0;
    sj_kana  = 1'b0;
    sj_dbl   = 1'b0;
    sj_bad   = 1'b0;
    eu_phase = EUC_START;
    eu_kana  = 1'b0;
    eu_dbl   = 1'b0;
    eu_p8f   = 1'b0;
    eu_bad   = 1'b0;
  endtask

  function automatic logic is_pair(input logic [7:0] b);
    return b >= BYTE_PAIR_LO && b <= BYTE_TOP;
  endfunction

  function automatic logic is_kana(input logic [7:0] b);
    return b >= BYTE_KANA_LO && b <= BYTE_KANA_HI;
  endfunction

  task automatic absorb_byte(input in_word_t w);
    logic [7:0] b;
    out_word_t  word;
    b = w.text_byte;
    if (!sj_bad) begin
      if (sj_wait) begin
        sj_wait = 1'b0;
        if (b >= BYTE_TRAIL_LO && b <= BYTE_TOP && b != BYTE_DEL) sj_dbl = 1'b1;
        else sj_bad = 1'b1;
      end else if (b == BYTE_NUL) begin
        sj_bad = 1'b1;
      end else if (is_kana(b)) begin
        sj_kana = 1'b1;
      end else if (b >= BYTE_LEAD_LO && b <= BYTE_TOP) begin
        sj_wait = 1'b1;
      end else if (b > BYTE_ASCII_HI) begin
        sj_bad = 1'b1;
      end
    end
    if (!eu_bad) begin
      case (eu_phase)
        EUC_KANA_NEXT: begin
          eu_phase = EUC_START;
          if (is_kana(b)) eu_kana = 1'b1;
          else eu_bad = 1'b1;
        end
        EUC_PAIR_FIRST: begin
          if (is_pair(b)) begin
            eu_phase = EUC_PAIR_SECOND;
          end else begin
            eu_phase = EUC_START;
            eu_bad = 1'b1;
          end
        end
        EUC_PAIR_SECOND: begin
          eu_phase = EUC_START;
          if (is_pair(b)) eu_dbl = 1'b1;
          else eu_bad = 1'b1;
        end
        default: begin
          if (b == BYTE_NUL) begin
            eu_bad = 1'b1;
          end else if (b == BYTE_SS2) begin
            eu_phase = EUC_KANA_NEXT;
          end else if (b == BYTE_SS3) begin
            eu_p8f = 1'b1;
            eu_phase = EUC_PAIR_FIRST;
          end else if (is_pair(b)) begin
            eu_phase = EUC_PAIR_SECOND;
          end else if (b > BYTE_ASCII_HI) begin
            eu_bad = 1'b1;
          end
        end
      endcase
    end
    if (w.stream_end) begin
      if (!last_ok) begin
        if (sj_wait) sj_bad = 1'b1;
        if (eu_phase != EUC_START) eu_bad = 1'b1;
      end
      word.sjis_score = sj_bad ? 3'd0 : sj_dbl ? 3'd4 : sj_kana ? 3'd3 : 3'd0;
      word.euc_score  = eu_bad ? 3'd0 :
                        eu_dbl ? ((eu_kana || eu_p8f) ? 3'd3 : 3'd4) :
                        eu_kana ? 3'd2 : 3'd0;
      score_q.push_back(word);
      clear_validators();
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst) begin
      last_ok = 1'b0;
      clear_validators();
      score_q.delete();
    end else begin
      if (pop && !empty) begin
        if (score_q.size() == 0) begin
          flag($sformatf("unexpected word sjis=%0d euc=%0d",
                         dout.sjis_score, dout.euc_score));
        end else begin
          want = score_q.pop_front();
          if (dout.sjis_score !== want.sjis_score || dout.euc_score !== want.euc_score) begin
            flag($sformatf("word mismatch: expected sjis=%0d euc=%0d, got sjis=%0d euc=%0d",
                           want.sjis_score, want.euc_score,
                           dout.sjis_score, dout.euc_score));
          end
        end
      end
      if (push && !full) absorb_byte(din);
      if (psel && penable && pready && paddr[JED_ADDR_W-1:2] == REG_LAST_BROKEN_OK) begin
        if (pwrite) begin
          last_ok = pwdata[0];
        end else if (prdata !== JED_DATA_W'(last_ok)) begin
          flag($sformatf("register read: expected %0h, got %0h", last_ok, prdata));
        end
      end
    end
    pending <= score_q.size();
  end

endmodule

[dv/testbench.sv]
// Testbench top: drives byte streams, register writes and reads into the detector.
`timescale 1ns / 1ps
module testbench;
  import jed_pkg::*;

  localparam int LIMIT = 200000;

  typedef enum int {
    CH_ASCII,
    CH_SJ_KANA,
    CH_SJ_DBL,
    CH_EU_KANA,
    CH_EU_PAIR,
    CH_EU_SS3,
    CH_NOISE
  } char_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  in_word_t              din = '0;
  logic                  full;
  logic                  empty;
  logic                  pop = 1'b0;
  out_word_t             dout;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [JED_ADDR_W-1:0] paddr = '0;
  logic [JED_DATA_W-1:0] pwdata = '0;
  logic [JED_DATA_W-1:0] prdata;
  logic                  pready;
  int                    mismatch_count;
  int                    pending;
  int                    cycle_count = 0;
  int                    items_sent = 0;
  logic                  idle_on = 1'b1;
  logic                  stall_on = 1'b1;
  logic [7:0]            text_q[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  japanese_encoding_detect_top u_top (
    .clk(clk), .rst(rst), .push(push), .din(din), .full(full), .empty(empty),
    .pop(pop), .dout(dout), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  jed_score_checker u_checker (
    .clk(clk), .rst(rst), .push(push), .full(full), .din(din), .empty(empty),
    .pop(pop), .dout(dout), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .mismatch_count(mismatch_count), .pending(pending)
  );

  always @(posedge clk) begin
    if (rst) pop <= 1'b0;
    else pop <= !(stall_on && $urandom_range(99) < 23);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic send(input logic [7:0] b, input logic e);
    while (idle_on && $urandom_range(99) < 23) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    din <= '{text_byte: b, stream_end: e};
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic drain();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  // write the tolerance bit, then read it back
  task automatic set_tolerance(input logic v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_LAST_BROKEN_OK, 2'b00};
    pwdata <= JED_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [7:0] sjis_lead();
    return $urandom_range(1) ? 8'($urandom_range(8'h9F, 8'h81))
                             : 8'($urandom_range(8'hFE, 8'hE0));
  endfunction

  function automatic logic [7:0] pair_byte();
    return 8'($urandom_range(8'hFE, BYTE_PAIR_LO));
  endfunction

  task automatic add_char(input char_kind_t k);
    logic [7:0] t;
    case (k)
      CH_ASCII:   text_q.push_back(8'($urandom_range(BYTE_ASCII_HI, 1)));
      CH_SJ_KANA: text_q.push_back(8'($urandom_range(BYTE_KANA_HI, BYTE_KANA_LO)));
      CH_SJ_DBL: begin
        text_q.push_back(sjis_lead());
        do t = 8'($urandom_range(BYTE_TOP, BYTE_TRAIL_LO)); while (t == BYTE_DEL);
        text_q.push_back(t);
      end
      CH_EU_KANA: begin
        text_q.push_back(BYTE_SS2);
        text_q.push_back(8'($urandom_range(BYTE_KANA_HI, BYTE_KANA_LO)));
      end
      CH_EU_PAIR: begin
        text_q.push_back(pair_byte());
        text_q.push_back(pair_byte());
      end
      CH_EU_SS3: begin
        text_q.push_back(BYTE_SS3);
        text_q.push_back(pair_byte());
        text_q.push_back(pair_byte());
      end
      default: text_q.push_back(8'($urandom_range(255)));
    endcase
  endtask

  task automatic send_stream();
    int         style;
    int         nchar;
    int         pick;
    char_kind_t k;
    text_q.delete();
    style = $urandom_range(9);
    nchar = ($urandom_range(9) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
    repeat (nchar) begin
      if ($urandom_range(99) < ((style == 9) ? 30 : 3)) begin
        k = CH_NOISE;
      end else if (style < 4) begin
        k = char_kind_t'($urandom_range(CH_SJ_DBL, CH_ASCII));
      end else if (style < 8) begin
        pick = $urandom_range(3);
        k = (pick == 0) ? CH_ASCII : char_kind_t'(int'(CH_EU_KANA) + pick - 1);
      end else begin
        k = char_kind_t'($urandom_range(CH_EU_SS3, CH_ASCII));
      end
      add_char(k);
    end
    // cut the last character short
    if ($urandom_range(99) < 15) begin
      case ($urandom_range(3))
        0: text_q.push_back(sjis_lead());
        1: text_q.push_back(BYTE_SS2);
        2: text_q.push_back(BYTE_SS3);
        default: begin
          text_q.push_back(BYTE_SS3);
          text_q.push_back(pair_byte());
        end
      endcase
    end
    foreach (text_q[i]) send(text_q[i], i == text_q.size() - 1);
  endtask

  initial begin
    int goal;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_tolerance(1'b0);
    send(8'h00, 1'b1);
    send(8'h7F, 1'b1);
    send(8'hA0, 1'b0); send(8'hDF, 1'b1);
    send(8'h81, 1'b0); send(8'h40, 1'b1);
    send(8'hFE, 1'b0); send(8'hFE, 1'b1);
    send(8'h8E, 1'b0); send(8'hA0, 1'b0); send(8'h8F, 1'b0);
    send(8'hA1, 1'b0); send(8'hFE, 1'b1);
    send(8'h81, 1'b0); send(8'h7F, 1'b1);
    send(8'h81, 1'b0); send(8'h00, 1'b1);
    send(8'h80, 1'b1);
    send(8'hFF, 1'b1);
    send(8'h81, 1'b1);
    drain();

    set_tolerance(1'b1);
    send(8'h8F, 1'b1);
    send(8'h8F, 1'b0); send(8'hA1, 1'b1);
    send(8'h8E, 1'b1);
    send(8'h81, 1'b1);
    send(8'hFF, 1'b1);
    send(8'h8E, 1'b0); send(8'hDF, 1'b1);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      set_tolerance(phase[0]);
      idle_on = (phase != 2);
      stall_on = (phase != 2);
      goal = items_sent + 325;
      while (items_sent < goal) send_stream();
      drain();
    end

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
